### hdl/buddy_block_allocator_assert.svh
// Assertion macros for the buddy block allocator checker.
`ifndef BUDDY_BLOCK_ALLOCATOR_ASSERT_SVH
`define BUDDY_BLOCK_ALLOCATOR_ASSERT_SVH
// Implication checked on every clock edge outside reset.
`define BBA_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define BBA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

### hdl/bba_pkg.sv
// ----------------------------------------------------------------------------
// bba_pkg
// Shared types and constants of the buddy block allocator.
// ----------------------------------------------------------------------------
package bba_pkg;
    localparam int HEAP_LOG2_DEF = 20;
    localparam int MIN_BLOCK_LOG2_DEF = 6;
    localparam int REQ_W = 32;
    localparam int OFF_W = 20;
    localparam int STAT_W = 3;
    localparam int LVL_W = 5;

    localparam logic [STAT_W-1:0] ST_OK = 3'd0;
    localparam logic [STAT_W-1:0] ST_NO_SPACE = 3'd1;
    localparam logic [STAT_W-1:0] ST_RANGE = 3'd2;
    localparam logic [STAT_W-1:0] ST_NOT_ALLOC = 3'd3;
    localparam logic [STAT_W-1:0] ST_MISALIGN = 3'd4;
    localparam logic [STAT_W-1:0] ST_ALREADY = 3'd5;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE = 1'b1;

    typedef struct packed {
        logic             op;
        logic [REQ_W-1:0] request_bytes;
        logic [OFF_W-1:0] release_offset;
    } t_req;

    typedef struct packed {
        logic [OFF_W-1:0]  block_offset;
        logic [STAT_W-1:0] status;
    } t_rsp;
endpackage

### hdl/bba_store.sv
// ----------------------------------------------------------------------------
// bba_store
// Per-block link and size record memories with registered reads.
// ----------------------------------------------------------------------------
module bba_store import bba_pkg::*; #(
    parameter int BLK_LOG2 = HEAP_LOG2_DEF - MIN_BLOCK_LOG2_DEF
) (
    input  logic                i_clk,
    input  logic [BLK_LOG2-1:0] i_raddr,
    output logic [BLK_LOG2:0]   o_rlink,
    output logic [LVL_W-1:0]    o_rsize,
    input  logic                i_lwe,
    input  logic [BLK_LOG2-1:0] i_laddr,
    input  logic [BLK_LOG2:0]   i_ldata,
    input  logic                i_swe,
    input  logic [BLK_LOG2-1:0] i_saddr,
    input  logic [LVL_W-1:0]    i_sdata
);
    logic [BLK_LOG2:0]  r_link [2**BLK_LOG2];
    logic [LVL_W-1:0]   r_size [2**BLK_LOG2];

    // link memory
    always_ff @(posedge i_clk) begin
        if (i_lwe) begin
            r_link[i_laddr] <= i_ldata;
        end
        o_rlink <= r_link[i_raddr];
    end

    // size record memory
    always_ff @(posedge i_clk) begin
        if (i_swe) begin
            r_size[i_saddr] <= i_sdata;
        end
        o_rsize <= r_size[i_raddr];
    end
endmodule

### hdl/buddy_block_allocator.sv
// ----------------------------------------------------------------------------
// buddy_block_allocator
// Buddy allocator over a power-of-two heap with per-level LIFO free lists.
// ----------------------------------------------------------------------------
// After reset a clearing pass writes all 2^(HEAP_LOG2-MIN_BLOCK_LOG2) link and
// size record entries (16384 by default), one a cycle, with busy high. One word
// at a time: an allocate steps up past empty levels in the search, reads and
// checks the head block, then splits one level per step; a release reads and
// checks the size record, then for each merge level walks the free list through
// the link memory entry by entry, which sets the worst case. The result strobe
// o_done lasts one cycle and cannot be held off; busy falls the cycle after.
module buddy_block_allocator import bba_pkg::*; #(
    parameter int HEAP_LOG2 = HEAP_LOG2_DEF,
    parameter int MIN_BLOCK_LOG2 = MIN_BLOCK_LOG2_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    output logic busy,
    input  t_req i_req,
    output logic o_done,
    output t_rsp o_rsp
);
    localparam int BL = HEAP_LOG2 - MIN_BLOCK_LOG2;
    localparam int NL = HEAP_LOG2;
    localparam int RESV = (BL > MIN_BLOCK_LOG2) ? BL : MIN_BLOCK_LOG2;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_ASRCH, S_ARD, S_ACHK, S_ASPLIT,
        S_FRD, S_FCHK, S_MSTEP, S_MRD, S_MCHK, S_PUSH, S_DONE
    } t_state;

    t_state r_state;
    t_req   r_req;
    logic [BL-1:0]    r_head [NL];
    logic [NL-1:0]    r_valid;
    logic [LVL_W-1:0] r_want, r_lvl;
    logic [BL-1:0]    r_blk, r_cur, r_prev;
    logic             r_hprev;
    logic [BL-1:0]    r_clr;
    t_rsp             r_rsp;

    logic [BL-1:0]  raddr, laddr, saddr;
    logic [BL:0]    rlink, ldata;
    logic [LVL_W-1:0] rsize, sdata;
    logic           lwe, swe;

    bba_store #(.BLK_LOG2(BL)) u_store (
        .i_clk(i_clk), .i_raddr(raddr), .o_rlink(rlink), .o_rsize(rsize),
        .i_lwe(lwe), .i_laddr(laddr), .i_ldata(ldata),
        .i_swe(swe), .i_saddr(saddr), .i_sdata(sdata)
    );

    // rounded level of the request
    logic [LVL_W-1:0] want_c;
    always_comb begin
        want_c = LVL_W'(MIN_BLOCK_LOG2);
        for (int k = 31; k >= MIN_BLOCK_LOG2; k--) begin
            if (i_req.request_bytes > (33'd1 << k) && k < 31) begin
                if (want_c < LVL_W'(k + 1)) want_c = LVL_W'(k + 1);
            end
        end
        if (i_req.request_bytes > 32'h8000_0000) want_c = 5'd31;
    end

    logic [BL-1:0] span;
    assign span = BL'(1) << (r_lvl - LVL_W'(MIN_BLOCK_LOG2));
    logic [OFF_W-1:0] fmask;
    assign fmask = OFF_W'((64'd1 << rsize) - 64'd1);
    logic off_range;
    assign off_range = (HEAP_LOG2 < OFF_W) &&
        ((i_req.release_offset >> HEAP_LOG2) != '0);

    // memory address and write mux
    always_comb begin
        raddr = r_cur;
        lwe = 1'b0; laddr = r_blk; ldata = '0;
        swe = 1'b0; saddr = r_blk; sdata = '0;
        unique case (r_state)
            S_CLEAR: begin
                lwe = 1'b1; swe = 1'b1;
                laddr = r_clr; saddr = r_clr;
            end
            S_ASPLIT: if (r_lvl > r_want) begin
                lwe = 1'b1; laddr = r_blk + (span >> 1);
                ldata = {r_valid[r_lvl - 5'd1], r_head[r_lvl - 5'd1]};
            end else begin
                swe = 1'b1; sdata = r_want;
            end
            S_FCHK: if (!(rsize == '0 || (r_req.release_offset & fmask) != '0)) begin
                swe = 1'b1; sdata = '0;
            end
            S_MCHK: if (r_cur == (r_blk ^ span) && r_hprev) begin
                lwe = 1'b1; laddr = r_prev; ldata = rlink;
            end
            S_PUSH: begin
                lwe = 1'b1; ldata = {r_valid[r_lvl], r_head[r_lvl]};
            end
            default: ;
        endcase
    end

    // control sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr <= '0;
            // initial split: one free block per level from RESV up, placed from the top down
            for (int l = 0; l < NL; l++) begin
                if (l >= RESV && l >= MIN_BLOCK_LOG2) begin
                    r_valid[l] <= 1'b1;
                    r_head[l] <= BL'(((1 << NL) - (1 << (l + 1))) >> MIN_BLOCK_LOG2);
                end else begin
                    r_valid[l] <= 1'b0;
                    r_head[l] <= '0;
                end
            end
        end else begin
            unique case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == BL'(2**BL - 1)) r_state <= S_IDLE;
                end
                S_IDLE: if (start) begin
                    r_req <= i_req;
                    r_rsp.block_offset <= '0;
                    if (i_req.op == OP_ALLOC) begin
                        r_rsp.status <= ST_OK;
                        r_want <= want_c;
                        r_lvl <= want_c;
                        r_state <= S_ASRCH;
                    end else if (off_range) begin
                        r_rsp.status <= ST_RANGE;
                        r_state <= S_DONE;
                    end else begin
                        r_rsp.status <= ST_OK;
                        r_cur <= BL'(i_req.release_offset >> MIN_BLOCK_LOG2);
                        r_blk <= BL'(i_req.release_offset >> MIN_BLOCK_LOG2);
                        r_state <= S_FRD;
                    end
                end
                S_ASRCH: begin
                    if (r_lvl >= LVL_W'(NL)) begin
                        r_rsp.status <= ST_NO_SPACE;
                        r_state <= S_DONE;
                    end else if (r_valid[r_lvl]) begin
                        r_cur <= r_head[r_lvl];
                        r_blk <= r_head[r_lvl];
                        r_state <= S_ARD;
                    end else begin
                        r_lvl <= r_lvl + 1'b1;
                    end
                end
                S_ARD: r_state <= S_ACHK;
                S_ACHK: begin
                    if (rsize != '0) begin
                        r_rsp.status <= ST_ALREADY;
                        r_state <= S_DONE;
                    end else begin
                        r_valid[r_lvl] <= rlink[BL];
                        r_head[r_lvl] <= rlink[BL-1:0];
                        r_state <= S_ASPLIT;
                    end
                end
                S_ASPLIT: begin
                    if (r_lvl > r_want) begin
                        r_head[r_lvl - 5'd1] <= r_blk + (span >> 1);
                        r_valid[r_lvl - 5'd1] <= 1'b1;
                        r_lvl <= r_lvl - 1'b1;
                    end else begin
                        r_rsp.block_offset <= OFF_W'({r_blk, MIN_BLOCK_LOG2'(0)});
                        r_state <= S_DONE;
                    end
                end
                S_FRD: r_state <= S_FCHK;
                S_FCHK: begin
                    if (rsize == '0) begin
                        r_rsp.status <= ST_NOT_ALLOC;
                        r_state <= S_DONE;
                    end else if ((r_req.release_offset & fmask) != '0) begin
                        r_rsp.status <= ST_MISALIGN;
                        r_state <= S_DONE;
                    end else begin
                        if (rsize < LVL_W'(MIN_BLOCK_LOG2)) r_lvl <= LVL_W'(MIN_BLOCK_LOG2);
                        else if (rsize > LVL_W'(NL - 1)) r_lvl <= LVL_W'(NL - 1);
                        else r_lvl <= rsize;
                        r_state <= S_MSTEP;
                    end
                end
                S_MSTEP: begin
                    if (r_lvl >= LVL_W'(NL - 1) || !r_valid[r_lvl]) begin
                        r_state <= S_PUSH;
                    end else begin
                        r_cur <= r_head[r_lvl];
                        r_hprev <= 1'b0;
                        r_state <= S_MRD;
                    end
                end
                S_MRD: r_state <= S_MCHK;
                S_MCHK: begin
                    if (r_cur == (r_blk ^ span)) begin
                        if (!r_hprev) begin
                            r_valid[r_lvl] <= rlink[BL];
                            r_head[r_lvl] <= rlink[BL-1:0];
                        end
                        r_blk <= r_blk & ~span;
                        r_lvl <= r_lvl + 1'b1;
                        r_state <= S_MSTEP;
                    end else if (!rlink[BL]) begin
                        r_state <= S_PUSH;
                    end else begin
                        r_hprev <= 1'b1;
                        r_prev <= r_cur;
                        r_cur <= rlink[BL-1:0];
                        r_state <= S_MRD;
                    end
                end
                S_PUSH: begin
                    r_head[r_lvl] <= r_blk;
                    r_valid[r_lvl] <= 1'b1;
                    r_state <= S_DONE;
                end
                S_DONE: r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign busy = (r_state != S_IDLE);
    assign o_done = (r_state == S_DONE);
    assign o_rsp = r_rsp;
endmodule

### hdl/bba_checker.sv
// ----------------------------------------------------------------------------
// bba_checker
// Port-level checks of the buddy block allocator.
// ----------------------------------------------------------------------------
`include "buddy_block_allocator_assert.svh"
module bba_checker import bba_pkg::*; (
    input logic i_clk,
    input logic i_rst_n,
    input logic start,
    input logic busy,
    input logic o_done,
    input t_rsp o_rsp
);
    // a result only comes while a word is in flight
    `BBA_ASSERT_IMPL(a_done_busy, i_clk, i_rst_n, o_done, busy)
    // results are single-cycle strobes
    `BBA_ASSERT_NEXT(a_done_pulse, i_clk, i_rst_n, o_done, !o_done && !busy)
    // accepted word makes the block busy
    `BBA_ASSERT_NEXT(a_accept, i_clk, i_rst_n, start && !busy, busy)
    // errors carry a zero offset
    `BBA_ASSERT_IMPL(a_err_off, i_clk, i_rst_n, o_done && o_rsp.status != ST_OK,
        o_rsp.block_offset == '0)
endmodule

bind buddy_block_allocator bba_checker u_bba_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
    .o_done(o_done), .o_rsp(o_rsp)
);

### tb/tb_buddy_block_allocator.sv
// ----------------------------------------------------------------------------
// tb_buddy_block_allocator
// Self-checking bench for the buddy block allocator. It sends allocate and
// release words, keeps its own model of the free lists and size records, and
// compares every result word in order with the predicted offset and status.
// ----------------------------------------------------------------------------
module tb_buddy_block_allocator;
    import bba_pkg::*;

    localparam int HL = HEAP_LOG2_DEF;
    localparam int ML = MIN_BLOCK_LOG2_DEF;
    localparam int BL = HL - ML;
    localparam int NB = 1 << BL;
    localparam int RL = (BL > ML) ? BL : ML;
    localparam int N_RANDOM = 1450;
    localparam longint CYCLE_LIMIT = 4000000;

    // Heap model: free lists, links, size records, expected results
    class heap_model;
        logic [BL-1:0] lhead [HL];
        bit            lvalid [HL];
        logic [BL:0]   nlink [NB];
        logic [4:0]    srec [NB];
        t_rsp          pending [$];
        int unsigned   held [$];

        function new();
            int base;
            for (int l = 0; l < HL; l++) begin
                lhead[l] = '0;
                lvalid[l] = 0;
            end
            for (int b = 0; b < NB; b++) begin
                nlink[b] = '0;
                srec[b] = '0;
            end
            base = 0;
            for (int l = HL - 1; l >= RL && l >= ML; l--) begin
                push_blk(l, base >> ML);
                base += 1 << l;
            end
        endfunction

        function void push_blk(int l, int blk);
            nlink[blk] = lvalid[l] ? {1'b1, lhead[l]} : '0;
            lhead[l] = blk[BL-1:0];
            lvalid[l] = 1;
        endfunction

        function bit unlink_blk(int l, int blk);
            bit have_prev;
            int prev, cur;
            bit live;
            logic [BL:0] nx;
            have_prev = 0;
            prev = 0;
            cur = lhead[l];
            live = lvalid[l];
            for (int g = 0; live && g < NB; g++) begin
                nx = nlink[cur];
                if (cur == blk) begin
                    if (have_prev) begin
                        nlink[prev] = nx;
                    end else begin
                        lvalid[l] = nx[BL];
                        lhead[l] = nx[BL-1:0];
                    end
                    return 1;
                end
                have_prev = 1;
                prev = cur;
                live = nx[BL];
                cur = nx[BL-1:0];
            end
            return 0;
        endfunction

        // Accepted request word: update the model and queue the expected result
        function void note(t_req rq);
            t_rsp r;
            longint req;
            int want, lvl, blk, s, span, hidx;
            logic [BL:0] nx;
            r.block_offset = '0;
            r.status = ST_OK;
            if (rq.op == OP_ALLOC) begin
                req = rq.request_bytes;
                if (req < (64'd1 << ML)) req = 64'd1 << ML;
                want = 0;
                while (want < 32 && (64'd1 << want) < req) want++;
                lvl = want;
                while (lvl < HL && !lvalid[lvl]) lvl++;
                if (lvl >= HL) begin
                    r.status = ST_NO_SPACE;
                end else begin
                    blk = lhead[lvl];
                    if (srec[blk] != 0) begin
                        r.status = ST_ALREADY;
                    end else begin
                        nx = nlink[blk];
                        lvalid[lvl] = nx[BL];
                        lhead[lvl] = nx[BL-1:0];
                        for (int t = lvl; t > want; t--)
                            push_blk(t - 1, blk + (1 << (t - 1 - ML)));
                        srec[blk] = want[4:0];
                        r.block_offset = OFF_W'(blk << ML);
                        held.push_back(blk << ML);
                    end
                end
            end else begin
                blk = rq.release_offset >> ML;
                s = srec[blk];
                if (s == 0) begin
                    r.status = ST_NOT_ALLOC;
                end else if ((rq.release_offset & ((1 << s) - 1)) != 0) begin
                    r.status = ST_MISALIGN;
                end else begin
                    srec[blk] = '0;
                    hidx = -1;
                    foreach (held[i]) if (held[i] == rq.release_offset) hidx = i;
                    if (hidx >= 0) held.delete(hidx);
                    if (s < ML) s = ML;
                    if (s > HL - 1) s = HL - 1;
                    // merge with free buddies upward
                    while (s < HL - 1) begin
                        span = 1 << (s - ML);
                        if (!unlink_blk(s, blk ^ span)) break;
                        blk = blk & ~span;
                        s++;
                    end
                    push_blk(s, blk);
                end
            end
            pending.push_back(r);
        endfunction

        // Result word against the oldest expectation
        function bit check(t_rsp got, output string why);
            t_rsp e;
            if (pending.size() == 0) begin
                why = $sformatf("unexpected result off=%h st=%0d",
                                got.block_offset, got.status);
                return 0;
            end
            e = pending.pop_front();
            if (got.status !== e.status || got.block_offset !== e.block_offset) begin
                why = $sformatf("got off=%h st=%0d, want off=%h st=%0d",
                                got.block_offset, got.status, e.block_offset, e.status);
                return 0;
            end
            return 1;
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    logic start;
    logic busy;
    t_req i_req;
    logic o_done;
    t_rsp o_rsp;

    int        n_errors;
    longint    cycles;
    heap_model heap;

    buddy_block_allocator i_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .start  (start),
        .busy   (busy),
        .i_req  (i_req),
        .o_done (o_done),
        .o_rsp  (o_rsp)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    task automatic report(string why);
        $display("mismatch @%0d: %s", cycles, why);
        n_errors++;
    endtask

    // Result monitor and timeout
    always @(posedge i_clk) begin
        string why;
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("[buddy_block_allocator] ERROR");
            $finish;
        end else if (i_rst_n && o_done) begin
            if (!heap.check(o_rsp, why)) report(why);
        end
    end

    // One request word; start stays high until accepted
    task automatic send(logic op, logic [REQ_W-1:0] bytes, logic [OFF_W-1:0] off);
        t_req rq;
        rq.op = op;
        rq.request_bytes = bytes;
        rq.release_offset = off;
        @(negedge i_clk);
        start <= 1'b1;
        i_req <= rq;
        do @(posedge i_clk); while (busy);
        heap.note(rq);
    endtask

    task automatic pause(int n);
        @(negedge i_clk);
        start <= 1'b0;
        repeat (n) @(negedge i_clk);
    endtask

    task automatic alloc(logic [REQ_W-1:0] bytes);
        send(OP_ALLOC, bytes, OFF_W'($urandom));
    endtask

    task automatic release_blk(logic [OFF_W-1:0] off);
        send(OP_FREE, $urandom, off);
    endtask

    // Random allocate, well-formed free of a held block, or a deliberately broken one
    task automatic random_item();
        int k, pick;
        int unsigned off;
        k = $urandom_range(0, 99);
        if (k < 45 && heap.held.size() < 300) begin
            if ($urandom_range(0, 19) == 0) alloc($urandom);
            else alloc($urandom_range(0, (1 << $urandom_range(0, 13))));
        end else if (k < 88 && heap.held.size() > 0) begin
            pick = $urandom_range(0, heap.held.size() - 1);
            release_blk(OFF_W'(heap.held[pick]));
        end else if (k < 94 && heap.held.size() > 0) begin
            pick = $urandom_range(0, heap.held.size() - 1);
            off = heap.held[pick] + $urandom_range(1, 63);
            release_blk(OFF_W'(off));
        end else begin
            release_blk(OFF_W'($urandom));
        end
    endtask

    initial begin
        int burst;
        int unsigned a;
        n_errors = 0;
        cycles = 0;
        heap = new();
        start = 1'b0;
        i_req = '0;
        i_rst_n = 1'b0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: tiny, exact, rounded, huge and bad requests
        alloc(32'd0);
        alloc(32'd1);
        alloc(32'd64);
        alloc(32'd65);
        alloc(32'h0008_0000);
        alloc(32'h0010_0000);
        alloc(32'h8000_0000);
        alloc(32'hFFFF_FFFF);
        alloc(32'd4096);
        a = heap.held[heap.held.size() - 1];
        release_blk(OFF_W'(a + 1));      // misaligned within a block
        release_blk(OFF_W'(a + 64));     // inside a block, slot not recorded
        release_blk(OFF_W'(a));
        release_blk(OFF_W'(a));          // double release
        release_blk(20'hFFFFF);
        release_blk(20'h0);
        while (heap.held.size() > 0) release_blk(OFF_W'(heap.held[0]));
        pause(2);

        // Random part in bursts with gaps
        burst = 0;
        for (int i = 0; i < N_RANDOM; i++) begin
            random_item();
            if (burst == 0) begin
                burst = $urandom_range(1, 25);
                if ($urandom_range(0, 2) != 0) pause($urandom_range(0, 6));
            end else begin
                burst--;
            end
        end
        @(negedge i_clk);
        start <= 1'b0;

        // Drain
        while (heap.pending.size() > 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (n_errors == 0) begin
            $display("[buddy_block_allocator] OK");
        end else begin
            $display("[buddy_block_allocator] ERROR");
        end
        $finish;
    end
endmodule
